// ----- hdl/ithm_pkg.sv -----
package ithm_pkg;

  localparam int unsigned MAX_SLOTS   = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned PTR_W       = SLOT_W + 1;
  localparam int unsigned ID_W        = 31;
  localparam int unsigned CAP_W       = 7;
  localparam int unsigned MIN_BUCKETS = 16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  // One slot memory word: stored id and the next link of the bucket chain.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PTR_W-1:0] next;
  } slot_word_t;

  // A link with the top bit set is null.
  localparam logic [PTR_W-1:0] PTR_NULL = {1'b1, {SLOT_W{1'b0}}};

endpackage

// ----- hdl/id_to_slot_hash_map.sv -----
// Maps ids to slots of a pool of up to 64 slots. An operation arrives as one transfer
// (op in tuser, id in tdata) and returns one result transfer. From the accepting edge to
// the edge that loads the result register, a lookup or remove reads the bucket head, then
// walks the chain, each chain step waiting on one registered read of the slot memory.
// An insert goes straight to the result when the table is full; otherwise it reads the
// head, runs the id mod capacity unit at four remainder bits per cycle, probes from the
// remainder past occupied slots, commits, and loads the result. The input is ready again
// once the result register loads; the result stage waits while an earlier result
// transfer is still held. Reset and capacity writes clear the table at once through
// per-entry valid flags; no clearing pass is needed.
module id_to_slot_hash_map
  import ithm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // id[30:0], zero[31]
  input  logic [1:0]  s_axis_tuser_i,  // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // status[1:0], slot[7:2], used_count[14:8], full_res[15]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [SLOT_W-1:0] h_q;
  logic [PTR_W-1:0]  hd_q;
  logic [SLOT_W-1:0] cur_q;
  logic [PTR_W-1:0]  prev_q;
  logic [ID_W-1:0]   prev_id_q;
  logic [CAP_W-1:0]  r_q, r_d;
  logic [2:0]        mcnt_q;
  logic [31:0]       idsh_q;
  logic [SLOT_W-1:0] k_q;
  status_e           res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              out_vld_q;
  logic [15:0]       out_data_q;
  logic [CAP_W-1:0]  used_q;
  logic [CAP_W-1:0]  cap_q;
  logic [SLOT_W-1:0] mask_q;
  logic [MAX_SLOTS-1:0] svld_q;
  logic [MAX_SLOTS-1:0] hvld_q;

  slot_word_t        slot_mem [MAX_SLOTS];
  logic [SLOT_W-1:0] head_mem [MAX_SLOTS];
  slot_word_t        slot_rd_q;
  logic [SLOT_W-1:0] head_rd_q;
  logic              head_vld_rd_q;

  logic              in_acc;
  logic              slot_re;
  logic [SLOT_W-1:0] slot_raddr;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  slot_word_t        slot_wdata;
  logic              head_we;
  logic [SLOT_W-1:0] head_wdata;
  logic [PTR_W-1:0]  head_ptr;
  logic              hit;
  logic [CAP_W:0]    t;
  logic [CAP_W-1:0]  cap_cl;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign head_ptr        = head_vld_rd_q ? {1'b0, head_rd_q} : PTR_NULL;
  assign hit             = (slot_rd_q.id == id_q);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_cl = 7'd1;
    end else if (cfg_wdata_i > CAP_W'(MAX_SLOTS)) begin
      cap_cl = CAP_W'(MAX_SLOTS);
    end else begin
      cap_cl = cfg_wdata_i;
    end
  end

  // Four restoring remainder steps per cycle; the remainder stays below capacity.
  always_comb begin
    r_d = r_q;
    t   = '0;
    for (int b = 0; b < 4; b++) begin
      t = {r_d, idsh_q[31-b]};
      if (t >= {1'b0, cap_q}) begin
        t = t - {1'b0, cap_q};
      end
      r_d = t[CAP_W-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    slot_re    = 1'b0;
    slot_raddr = cur_q;
    slot_we    = 1'b0;
    slot_waddr = k_q;
    slot_wdata = '{id: id_q, next: hd_q};
    head_we    = 1'b0;
    head_wdata = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (op_q == OP_INSERT) begin
          state_d = (used_q == cap_q) ? S_OUT : S_MOD;
        end else if (head_ptr[SLOT_W]) begin
          state_d = S_OUT;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = head_ptr[SLOT_W-1:0];
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        if (hit) begin
          state_d = S_OUT;
          if (op_q == OP_REMOVE) begin
            if (prev_q[SLOT_W]) begin
              head_we    = !slot_rd_q.next[SLOT_W];
              head_wdata = slot_rd_q.next[SLOT_W-1:0];
            end else begin
              slot_we    = 1'b1;
              slot_waddr = prev_q[SLOT_W-1:0];
              slot_wdata = '{id: prev_id_q, next: slot_rd_q.next};
            end
          end
        end else if (slot_rd_q.next[SLOT_W]) begin
          state_d = S_OUT;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = slot_rd_q.next[SLOT_W-1:0];
        end
      end
      S_MOD: begin
        if (mcnt_q == 3'd7) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!svld_q[k_q]) begin
          slot_we = 1'b1;
          head_we = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
    if (head_we) begin
      head_mem[h_q] <= head_wdata;
    end
    if (in_acc) begin
      head_rd_q <= head_mem[s_axis_tdata_i[SLOT_W-1:0] & mask_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_vld_q     <= 1'b0;
      used_q        <= '0;
      cap_q         <= CAP_W'(MAX_SLOTS);
      mask_q        <= SLOT_W'(MAX_SLOTS - 1);
      svld_q        <= '0;
      hvld_q        <= '0;
      head_vld_rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q  <= cap_cl;
        used_q <= '0;
        svld_q <= '0;
        hvld_q <= '0;
        if (cap_cl <= CAP_W'(MIN_BUCKETS)) begin
          mask_q <= SLOT_W'(MIN_BUCKETS - 1);
        end else if (cap_cl <= CAP_W'(2 * MIN_BUCKETS)) begin
          mask_q <= SLOT_W'(2 * MIN_BUCKETS - 1);
        end else begin
          mask_q <= SLOT_W'(MAX_SLOTS - 1);
        end
      end
      if (state_q == S_OUT && (!out_vld_q || m_axis_tready_i)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc) begin
        head_vld_rd_q <= hvld_q[s_axis_tdata_i[SLOT_W-1:0] & mask_q];
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q         <= op_e'(s_axis_tuser_i);
            id_q         <= s_axis_tdata_i[ID_W-1:0];
            h_q          <= s_axis_tdata_i[SLOT_W-1:0] & mask_q;
            idsh_q       <= {1'b0, s_axis_tdata_i[ID_W-1:0]};
            r_q          <= '0;
            mcnt_q       <= '0;
            prev_q       <= PTR_NULL;
            res_status_q <= ST_NOT_FOUND;
            res_slot_q   <= '0;
          end
        end
        S_HEAD: begin
          hd_q  <= head_ptr;
          cur_q <= head_ptr[SLOT_W-1:0];
          if (op_q == OP_INSERT) begin
            res_status_q <= ST_FULL;
          end
        end
        S_WALK: begin
          if (hit) begin
            res_status_q <= ST_OK;
            res_slot_q   <= cur_q;
            if (op_q == OP_REMOVE) begin
              svld_q[cur_q] <= 1'b0;
              used_q        <= used_q - 7'd1;
              if (prev_q[SLOT_W] && slot_rd_q.next[SLOT_W]) begin
                hvld_q[h_q] <= 1'b0;
              end
            end
          end else begin
            prev_q    <= {1'b0, cur_q};
            prev_id_q <= slot_rd_q.id;
            cur_q     <= slot_rd_q.next[SLOT_W-1:0];
          end
        end
        S_MOD: begin
          r_q    <= r_d;
          idsh_q <= {idsh_q[27:0], 4'd0};
          mcnt_q <= mcnt_q + 3'd1;
          k_q    <= r_d[SLOT_W-1:0];
        end
        S_PROBE: begin
          if (!svld_q[k_q]) begin
            svld_q[k_q]  <= 1'b1;
            hvld_q[h_q]  <= 1'b1;
            used_q       <= used_q + 7'd1;
            res_status_q <= ST_OK;
            res_slot_q   <= k_q;
          end else if ({1'b0, k_q} == cap_q - 7'd1) begin
            k_q <= '0;
          end else begin
            k_q <= k_q + 6'd1;
          end
        end
        S_OUT: begin
          if (!out_vld_q || m_axis_tready_i) begin
            out_data_q <= {(used_q == cap_q), used_q, res_slot_q, res_status_q};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/ithm_checker.sv -----
module ithm_assert
  import ithm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A result that reports a miss or a full table carries slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK) |-> (m_axis_tdata_o[7:2] == 6'd0))
    else $error("failed result carries a nonzero slot");

  // A full table never reports zero occupied slots.
  a_full_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[15]) |-> (m_axis_tdata_o[14:8] != 7'd0))
    else $error("full flag with empty table");

  // A table-full status only appears while the table is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] == ST_FULL) |-> m_axis_tdata_o[15])
    else $error("full status without full flag");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result transfer changed");

endmodule

bind id_to_slot_hash_map ithm_assert u_ithm_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
